FILE: hdl/clns_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clns_pkg
// Shared types, request codes, register indexes and byte tables of the
// character-LCD 4-bit write sequencer.
// ----------------------------------------------------------------------------
package clns_pkg;

  // Request codes carried on the slave-side tuser
  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_CMD   = 3'd1;
  localparam logic [2:0] OP_DATA  = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_HOME  = 3'd4;
  localparam logic [2:0] OP_PRINT = 3'd5;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_PULSE_WAIT    = 2'd0;
  localparam logic [1:0] REG_EXEC_WAIT     = 2'd1;
  localparam logic [1:0] REG_LONG_WAIT     = 2'd2;
  localparam logic [1:0] REG_POWER_ON_WAIT = 2'd3;

  // Command bytes
  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME  = 8'h02;
  localparam logic [7:0] CHAR_ZERO_HI = 8'h30;

  // Bytes in the init sequence and in the "Err" response
  localparam int unsigned INIT_BYTES = 6;
  localparam int unsigned ERR_BYTES  = 3;
  // Most decimal digits a 16-bit value can have
  localparam int unsigned VALUE_DIGITS = 5;

  // Source of the byte stream for the current request
  typedef enum logic [1:0] {
    K_INIT  = 2'd0,
    K_ONE   = 2'd1,
    K_ERR   = 2'd2,
    K_DIGIT = 2'd3
  } kind_t;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_POWER = 4'b0100,
    ST_BYTES = 4'b1000
  } state_t;

  // Init command bytes in order
  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h30;
      3'd1:    b = 8'h28;
      3'd2:    b = CMD_CLEAR;
      3'd3:    b = CMD_HOME;
      3'd4:    b = 8'h06;
      3'd5:    b = 8'h0C;
      default: b = 8'h0C;
    endcase
    return b;
  endfunction

  // "Err" characters
  function automatic logic [7:0] err_byte(input logic [2:0] idx);
    logic [7:0] b;
    if (idx == 3'd0) begin
      b = 8'h45;
    end else begin
      b = 8'h72;
    end
    return b;
  endfunction

  // 10 to the power n, evaluated at elaboration
  function automatic logic [31:0] pow10(input int n);
    logic [31:0] p;
    p = 32'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 32'd10;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/char_lcd_nibble_write_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Expands LCD requests into 4-bit bus events (nibble, RS, E, wait units).
//
// Usage:
//   Slave stream: tuser = request code (init, command, data, clear, home,
//   print number), tdata = 16-bit value. Master stream: one beat per bus
//   event, tlast on the final event of a request. APB port sets the four
//   wait registers; write them only while the block is idle.
//   The first event of a request passes through the input buffer, the
//   sequencer registers and the output register to the master stream; an
//   in-range print number first runs the divide-by-ten conversion unit, one
//   decimal digit at a time. Throughput: one event per cycle while the
//   receiver takes them, set by the single event sequencer; a request has
//   four events per byte, 25 for init. A one-beat input buffer takes the
//   next request while the current one is being expanded.
//   Reset: wait registers return to 1, 40, 1500 and 5000; buffer and output
//   register empty. When the receiver stalls, the output register holds its
//   beat and the sequencer waits; nothing is dropped.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer #(
  parameter int MAX_DIGITS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] value
  input  wire logic [2:0]  s_tuser,   // [2:0] op
  // bus event stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [3:0] nibble, [4] reg_select, [5] enable,
                                      // [23:6] wait_units
  output logic             m_tlast,   // last
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Digits that can actually occur and the counter widths that follow
  localparam int NDIG = (MAX_DIGITS < int'(clns_pkg::VALUE_DIGITS)) ?
                        MAX_DIGITS : int'(clns_pkg::VALUE_DIGITS);
  localparam int DW = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int CW = $clog2(NDIG + 1);
  localparam logic [31:0] LIMIT = clns_pkg::pow10(MAX_DIGITS);
  localparam logic [CW-1:0] NDIG_C = CW'(NDIG);

  // Configuration registers
  logic [15:0] pulse_wait;
  logic [15:0] exec_wait;
  logic [15:0] long_wait;
  logic [15:0] power_on_wait;

  // Input buffer
  logic        in_full;
  logic [2:0]  in_op;
  logic [15:0] in_value;

  // Sequencer
  clns_pkg::state_t state;
  clns_pkg::kind_t  kind;
  logic [7:0]  one_byte;
  logic        one_slow;
  logic        rs;
  logic [2:0]  nbytes;
  logic [2:0]  bidx;
  logic [1:0]  ph;

  // Digit conversion
  logic [15:0]   work;
  logic [CW-1:0] dcnt;
  logic [3:0]    digits [NDIG];
  logic [31:0]   prod;
  logic [12:0]   quot;
  logic [15:0]   rem_w;
  logic [3:0]    digit_rd;
  logic [2:0]    didx;

  logic        start;
  logic        emit;
  logic        ev_last;
  logic [7:0]  cur_byte;
  logic        cur_slow;
  logic [3:0]  ev_nibble;
  logic        ev_enable;
  logic [17:0] ev_wait;
  logic [17:0] end_wait;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Take a buffered request when the sequencer is free
  assign start    = in_full && (state == clns_pkg::ST_IDLE);
  assign s_tready = !in_full || start;

  // Divide the working value by ten through a reciprocal multiply
  assign prod  = 32'(work) * 32'd52429;
  assign quot  = prod[31:19];
  assign rem_w = work - {quot, 3'b000} - {2'b00, quot, 1'b0};

  // Digits go out most significant first
  assign didx     = nbytes - 3'd1 - bidx;
  assign digit_rd = digits[didx[DW-1:0]];

  // Pick the byte in flight
  always_comb begin
    unique case (kind)
      clns_pkg::K_INIT:  cur_byte = clns_pkg::init_byte(bidx);
      clns_pkg::K_ONE:   cur_byte = one_byte;
      clns_pkg::K_ERR:   cur_byte = clns_pkg::err_byte(bidx);
      clns_pkg::K_DIGIT: cur_byte = clns_pkg::CHAR_ZERO_HI | {4'h0, digit_rd};
      default:           cur_byte = one_byte;
    endcase
  end

  assign cur_slow = (kind == clns_pkg::K_INIT) ? ((bidx == 3'd2) || (bidx == 3'd3))
                                                : one_slow;
  assign end_wait = 18'(pulse_wait) + 18'(exec_wait) + (cur_slow ? 18'(long_wait) : 18'd0);

  // Build the event of the current step
  always_comb begin
    if (state == clns_pkg::ST_POWER) begin
      ev_nibble = 4'h0;
      ev_enable = 1'b0;
      ev_wait   = 18'(power_on_wait);
      ev_last   = 1'b0;
    end else begin
      ev_nibble = ph[1] ? cur_byte[3:0] : cur_byte[7:4];
      ev_enable = !ph[0];
      ev_wait   = (ph == 2'd3) ? end_wait : 18'(pulse_wait);
      ev_last   = (ph == 2'd3) && (bidx == nbytes - 3'd1);
    end
  end

  assign emit = ((state == clns_pkg::ST_POWER) || (state == clns_pkg::ST_BYTES)) &&
                (!m_tvalid || m_tready);

  // Register readback
  always_comb begin
    unique case (paddr[3:2])
      clns_pkg::REG_PULSE_WAIT:    prdata = {16'h0000, pulse_wait};
      clns_pkg::REG_EXEC_WAIT:     prdata = {16'h0000, exec_wait};
      clns_pkg::REG_LONG_WAIT:     prdata = {16'h0000, long_wait};
      clns_pkg::REG_POWER_ON_WAIT: prdata = {16'h0000, power_on_wait};
      default:                     prdata = 32'h0000_0000;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_wait    <= 16'd1;
      exec_wait     <= 16'd40;
      long_wait     <= 16'd1500;
      power_on_wait <= 16'd5000;
      in_full       <= 1'b0;
      m_tvalid      <= 1'b0;
      state         <= clns_pkg::ST_IDLE;
    end else begin
      // write configuration
      if (cfg_wr) begin
        unique case (paddr[3:2])
          clns_pkg::REG_PULSE_WAIT:    pulse_wait    <= pwdata[15:0];
          clns_pkg::REG_EXEC_WAIT:     exec_wait     <= pwdata[15:0];
          clns_pkg::REG_LONG_WAIT:     long_wait     <= pwdata[15:0];
          clns_pkg::REG_POWER_ON_WAIT: power_on_wait <= pwdata[15:0];
          default: ;
        endcase
      end

      // hold or drop the buffered request
      if (s_tvalid && s_tready) begin
        in_full <= 1'b1;
      end else if (start) begin
        in_full <= 1'b0;
      end

      // output register occupancy
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // advance the sequencer
      unique case (state)
        clns_pkg::ST_IDLE: begin
          if (start) begin
            unique case (in_op)
              clns_pkg::OP_INIT:  state <= clns_pkg::ST_POWER;
              clns_pkg::OP_CMD,
              clns_pkg::OP_DATA,
              clns_pkg::OP_CLEAR,
              clns_pkg::OP_HOME:  state <= clns_pkg::ST_BYTES;
              clns_pkg::OP_PRINT: begin
                if ({16'h0000, in_value} >= LIMIT) begin
                  state <= clns_pkg::ST_BYTES;
                end else begin
                  state <= clns_pkg::ST_CONV;
                end
              end
              default: state <= clns_pkg::ST_IDLE;
            endcase
          end
        end
        clns_pkg::ST_CONV: begin
          if (quot == 13'd0) begin
            state <= clns_pkg::ST_BYTES;
          end
        end
        clns_pkg::ST_POWER: begin
          if (emit) begin
            state <= clns_pkg::ST_BYTES;
          end
        end
        clns_pkg::ST_BYTES: begin
          if (emit && ev_last) begin
            state <= clns_pkg::ST_IDLE;
          end
        end
        default: state <= clns_pkg::ST_IDLE;
      endcase
    end
  end

  // Payload and step counters
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op    <= s_tuser;
      in_value <= s_tdata;
    end

    if (emit) begin
      m_tdata <= {ev_wait, ev_enable, rs, ev_nibble};
      m_tlast <= ev_last;
    end

    if (start) begin
      bidx     <= 3'd0;
      ph       <= 2'd0;
      dcnt     <= '0;
      work     <= in_value;
      one_slow <= 1'b0;
      one_byte <= in_value[7:0];
      rs       <= 1'b0;
      nbytes   <= 3'd1;
      kind     <= clns_pkg::K_ONE;
      unique case (in_op)
        clns_pkg::OP_INIT: begin
          kind   <= clns_pkg::K_INIT;
          nbytes <= 3'(clns_pkg::INIT_BYTES);
        end
        clns_pkg::OP_DATA: begin
          rs <= 1'b1;
        end
        clns_pkg::OP_CLEAR: begin
          one_byte <= clns_pkg::CMD_CLEAR;
          one_slow <= 1'b1;
        end
        clns_pkg::OP_HOME: begin
          one_byte <= clns_pkg::CMD_HOME;
          one_slow <= 1'b1;
        end
        clns_pkg::OP_PRINT: begin
          rs <= 1'b1;
          if ({16'h0000, in_value} >= LIMIT) begin
            kind   <= clns_pkg::K_ERR;
            nbytes <= 3'(clns_pkg::ERR_BYTES);
          end else begin
            kind <= clns_pkg::K_DIGIT;
          end
        end
        default: ;
      endcase
    end else if (state == clns_pkg::ST_CONV) begin
      // peel one decimal digit per cycle, least significant first
      digits[dcnt[DW-1:0]] <= rem_w[3:0];
      dcnt                 <= dcnt + CW'(1);
      work                 <= 16'(quot);
      if (quot == 13'd0) begin
        nbytes <= 3'(dcnt) + 3'd1;
      end
    end else if (emit && (state == clns_pkg::ST_BYTES)) begin
      ph <= ph + 2'd1;
      if ((ph == 2'd3) && !ev_last) begin
        bidx <= bidx + 3'd1;
      end
    end
  end

  // A held request stays until the sequencer takes it
  a_buffer_holds: assert property (@(posedge clk) disable iff (rst)
    in_full && !start |=> in_full)
    else $error("request buffer lost its entry");

  // An enable-high event never ends a request
  a_last_on_low: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tdata[5])
    else $error("last event has enable high");

  // Enable-high events hold exactly the pulse wait
  a_pulse_wait: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5] |-> m_tdata[23:6] == 18'(pulse_wait))
    else $error("enable-high event wait mismatch");

  // Digit conversion never runs past the digit store
  a_digit_room: assert property (@(posedge clk) disable iff (rst)
    state == clns_pkg::ST_CONV |-> dcnt < NDIG_C)
    else $error("digit store overflow");

  // Sequencer leaves idle only on a buffered request
  a_start_only: assert property (@(posedge clk) disable iff (rst)
    state == clns_pkg::ST_IDLE && !in_full |=> state == clns_pkg::ST_IDLE)
    else $error("sequencer started without a request");

endmodule
`default_nettype wire

FILE: verif/char_lcd_nibble_write_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_test
// Self-checking bench for the 4-bit character-LCD write sequencer. Requests
// go in on the slave stream and bus events come out on the master stream.
// A behavioral predictor expands each accepted request into its expected
// events, which are checked field by field in order. A directed table runs
// first, then random phases, each under a new set of wait registers. Both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_test;

  localparam int          PRINT_DIGITS    = 4;
  localparam int unsigned PRINT_LIMIT     = 10 ** PRINT_DIGITS;
  localparam int          RANDOM_PHASES   = 8;
  localparam int          ITEMS_PER_PHASE = 60;
  localparam int          IDLE_SETTLE     = 16;

  // Request codes with no meaning; the block drops them
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  // Characters used when printing a number
  localparam logic [7:0] CHAR_DIGIT0  = 8'h30;
  localparam logic [7:0] CHAR_E       = 8'h45;
  localparam logic [7:0] CHAR_LOWER_R = 8'h72;

  // Init command bytes, first byte in the low bits
  localparam logic [47:0] INIT_CMD_BYTES = {8'h0C, 8'h06, clns_pkg::CMD_HOME,
                                            clns_pkg::CMD_CLEAR, 8'h28, 8'h30};

  typedef struct packed {
    logic [3:0]  nibble;
    logic        reg_select;
    logic        enable;
    logic [17:0] wait_units;
    logic        last;
  } lcd_event_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] value;
    logic        typed;
    lcd_event_t  final_event;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [15:0] value
  logic [2:0]  s_tuser;   // [2:0] op
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [3:0] nibble, [4] reg_select, [5] enable, [23:6] wait_units
  logic        m_tlast;   // last
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the wait registers
  logic [15:0] cfg_pulse_wait    = 16'd1;
  logic [15:0] cfg_exec_wait     = 16'd40;
  logic [15:0] cfg_long_wait     = 16'd1500;
  logic [15:0] cfg_power_on_wait = 16'd5000;

  lcd_event_t lcd_events_due [$];
  int unsigned error_total = 0;
  logic sender_steady = 1'b0;

  // Directed requests; the final event is typed in where it is plain to see
  directed_row_t directed_rows [0:20] = '{
    '{clns_pkg::OP_INIT,  16'h0000, 1'b1, '{4'hC, 1'b0, 1'b0, 18'd41,   1'b1}},
    '{clns_pkg::OP_CMD,   16'h0000, 1'b0, '0},
    '{clns_pkg::OP_CMD,   16'hFFFF, 1'b1, '{4'hF, 1'b0, 1'b0, 18'd41,   1'b1}},
    '{clns_pkg::OP_DATA,  16'h0041, 1'b0, '0},
    '{clns_pkg::OP_DATA,  16'hAB00, 1'b1, '{4'h0, 1'b1, 1'b0, 18'd41,   1'b1}},
    '{clns_pkg::OP_DATA,  16'h00FF, 1'b0, '0},
    '{clns_pkg::OP_CLEAR, 16'h0000, 1'b1, '{4'h1, 1'b0, 1'b0, 18'd1541, 1'b1}},
    '{clns_pkg::OP_HOME,  16'hFFFF, 1'b1, '{4'h2, 1'b0, 1'b0, 18'd1541, 1'b1}},
    '{clns_pkg::OP_CMD,   16'h0001, 1'b1, '{4'h1, 1'b0, 1'b0, 18'd41,   1'b1}},
    '{clns_pkg::OP_PRINT, 16'd0,    1'b1, '{4'h0, 1'b1, 1'b0, 18'd41,   1'b1}},
    '{clns_pkg::OP_PRINT, 16'd7,    1'b0, '0},
    '{clns_pkg::OP_PRINT, 16'd10,   1'b0, '0},
    '{clns_pkg::OP_PRINT, 16'd100,  1'b0, '0},
    '{clns_pkg::OP_PRINT, 16'd1000, 1'b0, '0},
    '{clns_pkg::OP_PRINT, 16'd9999, 1'b1, '{4'h9, 1'b1, 1'b0, 18'd41,   1'b1}},
    '{clns_pkg::OP_PRINT, 16'd10000, 1'b1, '{4'h2, 1'b1, 1'b0, 18'd41,  1'b1}},
    '{clns_pkg::OP_PRINT, 16'hFFFF, 1'b1, '{4'h2, 1'b1, 1'b0, 18'd41,   1'b1}},
    '{OP_SPARE6, 16'd1234, 1'b0, '0},
    '{OP_SPARE7, 16'hFFFF, 1'b0, '0},
    '{clns_pkg::OP_PRINT, 16'd5,    1'b0, '0},
    '{clns_pkg::OP_INIT,  16'h5A5A, 1'b0, '0}
  };

  char_lcd_nibble_write_sequencer #(
    .MAX_DIGITS(PRINT_DIGITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Queue the four events of one byte, high nibble first
  function automatic void queue_byte(input logic [7:0] b, input logic rs, input logic slow);
    logic [17:0] tail_wait;
    tail_wait = 18'(cfg_pulse_wait) + 18'(cfg_exec_wait) + (slow ? 18'(cfg_long_wait) : 18'd0);
    lcd_events_due.push_back(lcd_event_t'{b[7:4], rs, 1'b1, 18'(cfg_pulse_wait), 1'b0});
    lcd_events_due.push_back(lcd_event_t'{b[7:4], rs, 1'b0, 18'(cfg_pulse_wait), 1'b0});
    lcd_events_due.push_back(lcd_event_t'{b[3:0], rs, 1'b1, 18'(cfg_pulse_wait), 1'b0});
    lcd_events_due.push_back(lcd_event_t'{b[3:0], rs, 1'b0, tail_wait, 1'b0});
  endfunction

  // Expand one request into the bus events it should produce
  function automatic void predict_bus_events(input logic [2:0] op, input logic [15:0] value);
    int unsigned first_slot;
    int unsigned rest;
    int unsigned n_digits;
    logic [7:0]  init_cmd;
    logic [7:0]  digit_chars [PRINT_DIGITS];
    lcd_event_t  tail;
    first_slot = lcd_events_due.size();
    case (op)
      clns_pkg::OP_INIT: begin
        lcd_events_due.push_back(lcd_event_t'{4'h0, 1'b0, 1'b0, 18'(cfg_power_on_wait), 1'b0});
        for (int i = 0; i < 6; i++) begin
          init_cmd = INIT_CMD_BYTES[8*i +: 8];
          queue_byte(init_cmd, 1'b0,
                     init_cmd == clns_pkg::CMD_CLEAR || init_cmd == clns_pkg::CMD_HOME);
        end
      end
      clns_pkg::OP_CMD:   queue_byte(value[7:0], 1'b0, 1'b0);
      clns_pkg::OP_DATA:  queue_byte(value[7:0], 1'b1, 1'b0);
      clns_pkg::OP_CLEAR: queue_byte(clns_pkg::CMD_CLEAR, 1'b0, 1'b1);
      clns_pkg::OP_HOME:  queue_byte(clns_pkg::CMD_HOME, 1'b0, 1'b1);
      clns_pkg::OP_PRINT: begin
        if (value >= PRINT_LIMIT) begin
          queue_byte(CHAR_E, 1'b1, 1'b0);
          queue_byte(CHAR_LOWER_R, 1'b1, 1'b0);
          queue_byte(CHAR_LOWER_R, 1'b1, 1'b0);
        end else if (value == 16'd0) begin
          queue_byte(CHAR_DIGIT0, 1'b1, 1'b0);
        end else begin
          // Collect digits least significant first, send most significant first
          rest = value;
          n_digits = 0;
          while (rest != 0) begin
            digit_chars[n_digits] = CHAR_DIGIT0 + 8'(rest % 10);
            rest = rest / 10;
            n_digits++;
          end
          for (int i = int'(n_digits) - 1; i >= 0; i--) begin
            queue_byte(digit_chars[i], 1'b1, 1'b0);
          end
        end
      end
      default: ;
    endcase
    // Mark the final event of the request
    if (lcd_events_due.size() > first_slot) begin
      tail = lcd_events_due.pop_back();
      tail.last = 1'b1;
      lcd_events_due.push_back(tail);
    end
  endfunction

  task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_total++;
    end
  endtask

  // Check each accepted bus event against the oldest expectation
  always @(posedge clk) begin : event_check
    lcd_event_t due;
    if (!rst && m_tvalid && m_tready) begin
      if (lcd_events_due.size() == 0) begin
        $error("bus event 0x%06h arrived with no request pending", m_tdata);
        error_total++;
      end else begin
        due = lcd_events_due.pop_front();
        compare_field("nibble", due.nibble, m_tdata[3:0]);
        compare_field("reg_select", due.reg_select, m_tdata[4]);
        compare_field("enable", due.enable, m_tdata[5]);
        compare_field("wait_units", due.wait_units, m_tdata[23:6]);
        compare_field("last", due.last, m_tlast);
      end
    end
  end

  // Event sink: stall a random number of cycles ahead of each beat
  initial begin : event_sink
    int unsigned stall;
    logic sink_steady;
    sink_steady = 1'b0;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
      stall = sink_steady ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  // Write one wait register through the APB port; call at a falling edge
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      clns_pkg::REG_PULSE_WAIT:    cfg_pulse_wait = val;
      clns_pkg::REG_EXEC_WAIT:     cfg_exec_wait = val;
      clns_pkg::REG_LONG_WAIT:     cfg_long_wait = val;
      clns_pkg::REG_POWER_ON_WAIT: cfg_power_on_wait = val;
      default: ;
    endcase
  endtask

  // Offer one request after a random gap and predict it once accepted
  task automatic send_request(input logic [2:0] op, input logic [15:0] value,
                              input logic typed, input lcd_event_t final_event);
    int unsigned gap;
    gap = sender_steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    predict_bus_events(op, value);
    // Hand-typed final event replaces the predicted one
    if (typed) begin
      void'(lcd_events_due.pop_back());
      lcd_events_due.push_back(final_event);
    end
    @(negedge clk);
  endtask

  // Hold off new requests until every expected event has come out
  task automatic drain_requests();
    s_tvalid <= 1'b0;
    while (lcd_events_due.size() != 0) @(negedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_wait(input int phase);
    logic [15:0] val;
    case (phase)
      0: val = 16'd0;
      1: val = 16'hFFFF;
      default: begin
        case ($urandom_range(0, 3))
          0:       val = 16'd0;
          1:       val = 16'hFFFF;
          2:       val = 16'($urandom_range(0, 15));
          default: val = 16'($urandom);
        endcase
      end
    endcase
    return val;
  endfunction

  initial begin : stimulus
    int unsigned pick;
    int unsigned counted;
    logic [2:0]  op;
    logic [15:0] value;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset register values
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].final_event);
    end
    drain_requests();

    // Random phases, each under a new register set
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_reg(clns_pkg::REG_PULSE_WAIT, pick_wait(phase));
      write_reg(clns_pkg::REG_EXEC_WAIT, pick_wait(phase));
      write_reg(clns_pkg::REG_LONG_WAIT, pick_wait(phase));
      write_reg(clns_pkg::REG_POWER_ON_WAIT, pick_wait(phase));
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 19) == 0) sender_steady = !sender_steady;
        pick  = $urandom_range(0, 99);
        value = 16'($urandom);
        if (pick < 5) begin
          op = clns_pkg::OP_INIT;
        end else if (pick < 25) begin
          op = clns_pkg::OP_CMD;
        end else if (pick < 45) begin
          op = clns_pkg::OP_DATA;
        end else if (pick < 52) begin
          op = clns_pkg::OP_CLEAR;
        end else if (pick < 59) begin
          op = clns_pkg::OP_HOME;
        end else if (pick < 94) begin
          op = clns_pkg::OP_PRINT;
          // Spread numbers over every digit count and around the limit
          case ($urandom_range(0, 5))
            0: value = 16'($urandom_range(0, 9));
            1: value = 16'($urandom_range(10, 99));
            2: value = 16'($urandom_range(100, 999));
            3: value = 16'($urandom_range(1000, PRINT_LIMIT - 1));
            4: value = 16'($urandom_range(PRINT_LIMIT - 10, PRINT_LIMIT + 10));
            default: ;
          endcase
        end else begin
          op = ($urandom_range(0, 1) == 0) ? OP_SPARE6 : OP_SPARE7;
        end
        send_request(op, value, 1'b0, '0);
        if (op != OP_SPARE6 && op != OP_SPARE7) counted++;
      end
      drain_requests();
    end

    // Let any stray event show up before the verdict
    repeat (32) @(posedge clk);
    if (error_total == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin : watchdog
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
